@@ hdl/btpc_pkg.sv @@
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants for the barometric temperature and pressure
// compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

    // calibration words, one per configuration register
    typedef struct packed {
        logic [15:0] sens_base;
        logic [15:0] offset_base;
        logic [15:0] sens_tempco;
        logic [15:0] offset_tempco;
        logic [15:0] ref_temperature;
        logic [15:0] temp_sensitivity;
    } t_cal;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SENS_BASE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BASE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMPCO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMPCO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMPERATURE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENSITIVITY = 3'd5;

    localparam int unsigned RAW_W   = 24;
    localparam int unsigned TEMP_W  = 15;
    localparam int unsigned PRESS_W = 17;

    // second-order temperature thresholds, 0.01 C
    localparam int T_REF  = 2000;
    localparam int T_KNEE = -1500;

    localparam int TEMP_LOW   = -4000;
    localparam int TEMP_HIGH  = 8500;
    localparam int PRESS_HIGH = 131071;

    // clock edges from the accepting edge to the edge that raises the strobe
    localparam int unsigned LATENCY = 8;

endpackage

@@ hdl/btpc_calc.sv @@
// ----------------------------------------------------------------------------
// btpc_calc
// Compensation datapath: dT, first-order terms, second-order
// corrections, split pressure product and output saturation.
// ----------------------------------------------------------------------------
module btpc_calc (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [btpc_pkg::RAW_W-1:0]           i_raw_temperature,
    input  logic [btpc_pkg::RAW_W-1:0]           i_raw_pressure,
    input  btpc_pkg::t_cal                       i_cal,
    output logic                                 o_valid,
    output logic signed [btpc_pkg::TEMP_W-1:0]   o_temperature_centi,
    output logic [btpc_pkg::PRESS_W-1:0]         o_pressure_centi_mbar
);

    localparam int unsigned NSTG = btpc_pkg::LATENCY + 1;

    // valid bit of each stage register
    logic [NSTG-1:0] r_vld;

    // stage 0
    logic [btpc_pkg::RAW_W-1:0] r_d2;
    logic [btpc_pkg::RAW_W-1:0] r_d1_pipe [0:5];

    // stage 1
    logic signed [25:0] r_dt;
    logic signed [25:0] n_dt;

    // stage 2
    logic signed [42:0] n_dt_c6;
    logic signed [42:0] n_c4_dt;
    logic signed [42:0] n_c3_dt;
    logic signed [51:0] n_dt_sq;
    logic signed [40:0] r_dt_c6;
    logic signed [40:0] r_c4_dt;
    logic signed [40:0] r_c3_dt;
    logic [47:0]        r_dt_sq;

    // stage 3
    logic signed [17:0] n_a;
    logic signed [18:0] n_b;
    logic signed [34:0] n_off;
    logic signed [33:0] n_sens;
    logic signed [17:0] r_a;
    logic signed [18:0] r_b;
    logic [16:0]        r_t2;
    logic signed [34:0] r_off3;
    logic signed [33:0] r_sens3;
    logic               r_lt_ref3;
    logic               r_lt_knee3;

    // stage 4
    logic signed [18:0] n_t1;
    logic signed [19:0] n_tc;
    logic [btpc_pkg::TEMP_W-1:0] n_temp;
    logic signed [35:0] n_sq;
    logic signed [37:0] n_sq2;
    logic [33:0]        r_sq;
    logic [33:0]        r_sq2;
    logic signed [34:0] r_off4;
    logic signed [33:0] r_sens4;
    logic               r_lt_ref4;
    logic               r_lt_knee4;
    logic [btpc_pkg::TEMP_W-1:0] r_temp_pipe [0:4];

    // stage 5
    logic [36:0]        n_sq5;
    logic [36:0]        n_sq2_7;
    logic [37:0]        n_sq2_11;
    logic [37:0]        n_off2;
    logic [37:0]        n_sens2;
    logic signed [39:0] n_offc;
    logic signed [39:0] n_sensc;
    logic signed [39:0] r_offc5;
    logic signed [39:0] r_sensc;

    // stage 6
    logic [43:0]        n_plo;
    logic signed [44:0] n_phi;
    logic [43:0]        r_plo;
    logic signed [44:0] r_phi;
    logic signed [39:0] r_offc6;

    // stage 7
    logic signed [63:0] n_prod;
    logic signed [63:0] r_prod;
    logic signed [39:0] r_offc7;

    // stage 8
    logic signed [43:0] n_x;
    logic signed [28:0] n_p;
    logic [btpc_pkg::PRESS_W-1:0] n_press;
    logic [btpc_pkg::PRESS_W-1:0] r_press;

    always_comb begin
        n_dt = $signed({2'b00, r_d2}) - $signed({2'b00, i_cal.ref_temperature, 8'h00});

        n_dt_c6 = r_dt * $signed({1'b0, i_cal.temp_sensitivity});
        n_c4_dt = r_dt * $signed({1'b0, i_cal.offset_tempco});
        n_c3_dt = r_dt * $signed({1'b0, i_cal.sens_tempco});
        n_dt_sq = r_dt * r_dt;

        // a = TEMP - 2000, b = TEMP + 1500
        n_a    = r_dt_c6[40:23];
        n_b    = $signed({n_a[17], n_a})
               + $signed(19'(btpc_pkg::T_REF - btpc_pkg::T_KNEE));
        n_off  = $signed({3'b000, i_cal.offset_base, 16'h0000})
               + $signed({r_c4_dt[40], r_c4_dt[40:7]});
        n_sens = $signed({3'b000, i_cal.sens_base, 15'h0000})
               + $signed({r_c3_dt[40], r_c3_dt[40:8]});

        n_t1 = $signed({r_a[17], r_a}) + $signed(19'(btpc_pkg::T_REF));
        n_tc = $signed({n_t1[18], n_t1}) - $signed({3'b000, r_lt_ref3 ? r_t2 : 17'd0});
        if (n_tc < $signed(20'(btpc_pkg::TEMP_LOW))) begin
            n_temp = btpc_pkg::TEMP_W'(btpc_pkg::TEMP_LOW);
        end else if (n_tc > $signed(20'(btpc_pkg::TEMP_HIGH))) begin
            n_temp = btpc_pkg::TEMP_W'(btpc_pkg::TEMP_HIGH);
        end else begin
            n_temp = n_tc[btpc_pkg::TEMP_W-1:0];
        end
        n_sq  = r_a * r_a;
        n_sq2 = r_b * r_b;

        // second-order corrections, all terms non-negative
        n_sq5    = {1'b0, r_sq, 2'b00} + {3'b000, r_sq};
        n_sq2_7  = {r_sq2, 3'b000} - {3'b000, r_sq2};
        n_sq2_11 = {1'b0, r_sq2, 3'b000} + {3'b000, r_sq2, 1'b0} + {4'b0000, r_sq2};
        if (r_lt_ref4) begin
            n_off2  = {2'b00, n_sq5[36:1]} + (r_lt_knee4 ? {1'b0, n_sq2_7} : 38'd0);
            n_sens2 = {3'b000, n_sq5[36:2]} + (r_lt_knee4 ? {1'b0, n_sq2_11[37:1]} : 38'd0);
        end else begin
            n_off2  = 38'd0;
            n_sens2 = 38'd0;
        end
        n_offc  = $signed({{5{r_off4[34]}}, r_off4}) - $signed({2'b00, n_off2});
        n_sensc = $signed({{6{r_sens4[33]}}, r_sens4}) - $signed({2'b00, n_sens2});

        // D1 * SENS split into two partial products
        n_plo = r_d1_pipe[5] * r_sensc[19:0];
        n_phi = $signed({1'b0, r_d1_pipe[5]}) * $signed(r_sensc[39:20]);

        n_prod = $signed({r_phi[43:0], 20'h00000}) + $signed({20'h00000, r_plo});

        n_x = $signed({r_prod[63], r_prod[63:21]}) - $signed({{4{r_offc7[39]}}, r_offc7});
        n_p = n_x[43:15];
        if (n_p[28]) begin
            n_press = '0;
        end else if (n_p > $signed(29'(btpc_pkg::PRESS_HIGH))) begin
            n_press = btpc_pkg::PRESS_W'(btpc_pkg::PRESS_HIGH);
        end else begin
            n_press = n_p[btpc_pkg::PRESS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d2         <= i_raw_temperature;
        r_d1_pipe[0] <= i_raw_pressure;
        for (int i = 1; i < 6; i++) begin
            r_d1_pipe[i] <= r_d1_pipe[i-1];
        end

        r_dt <= n_dt;

        r_dt_c6 <= n_dt_c6[40:0];
        r_c4_dt <= n_c4_dt[40:0];
        r_c3_dt <= n_c3_dt[40:0];
        r_dt_sq <= n_dt_sq[47:0];

        r_a        <= n_a;
        r_b        <= n_b;
        r_t2       <= r_dt_sq[47:31];
        r_off3     <= n_off;
        r_sens3    <= n_sens;
        r_lt_ref3  <= n_a[17];
        r_lt_knee3 <= n_b[18];

        r_sq           <= n_sq[33:0];
        r_sq2          <= n_sq2[33:0];
        r_off4         <= r_off3;
        r_sens4        <= r_sens3;
        r_lt_ref4      <= r_lt_ref3;
        r_lt_knee4     <= r_lt_knee3;
        r_temp_pipe[0] <= n_temp;
        for (int i = 1; i < 5; i++) begin
            r_temp_pipe[i] <= r_temp_pipe[i-1];
        end

        r_offc5 <= n_offc;
        r_sensc <= n_sensc;

        r_plo   <= n_plo;
        r_phi   <= n_phi;
        r_offc6 <= r_offc5;

        r_prod  <= n_prod;
        r_offc7 <= r_offc6;

        r_press <= n_press;
    end

    assign o_valid               = r_vld[NSTG-1];
    assign o_temperature_centi   = r_temp_pipe[4];
    assign o_pressure_centi_mbar = r_press;

endmodule

@@ hdl/baro_temp_pressure_compensation_top.sv @@
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top
// Second-order barometric compensation: calibration registers and pipeline.
// ----------------------------------------------------------------------------
// o_valid is the taken start carried through the btpc_calc stage valid bits
// throughput: one transaction per cycle, busy stays low; results appear
// for one cycle and cannot be held off
// reset clears the calibration words to zero and drops transactions in flight
module baro_temp_pressure_compensation_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [btpc_pkg::RAW_W-1:0]              i_raw_temperature,
    input  logic [btpc_pkg::RAW_W-1:0]              i_raw_pressure,
    output logic                                    o_valid,
    output logic signed [btpc_pkg::TEMP_W-1:0]      o_temperature_centi,
    output logic [btpc_pkg::PRESS_W-1:0]            o_pressure_centi_mbar,
    input  logic                                    i_cfg_we,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [btpc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    btpc_pkg::t_cal r_cal;
    logic           w_accept;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                btpc_pkg::REG_SENS_BASE:        r_cal.sens_base        <= i_cfg_data;
                btpc_pkg::REG_OFFSET_BASE:      r_cal.offset_base      <= i_cfg_data;
                btpc_pkg::REG_SENS_TEMPCO:      r_cal.sens_tempco      <= i_cfg_data;
                btpc_pkg::REG_OFFSET_TEMPCO:    r_cal.offset_tempco    <= i_cfg_data;
                btpc_pkg::REG_REF_TEMPERATURE:  r_cal.ref_temperature  <= i_cfg_data;
                btpc_pkg::REG_TEMP_SENSITIVITY: r_cal.temp_sensitivity <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    btpc_calc u_calc (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (w_accept),
        .i_raw_temperature     (i_raw_temperature),
        .i_raw_pressure        (i_raw_pressure),
        .i_cal                 (r_cal),
        .o_valid               (o_valid),
        .o_temperature_centi   (o_temperature_centi),
        .o_pressure_centi_mbar (o_pressure_centi_mbar)
    );

    // every result traces back to an earlier accepted transaction
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, btpc_pkg::LATENCY + 1))
        else $error("result strobe without a matching transaction");

    a_temp_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_centi >= $signed(15'(btpc_pkg::TEMP_LOW)))
                 && (o_temperature_centi <= $signed(15'(btpc_pkg::TEMP_HIGH))))
        else $error("temperature outside saturation range");

    a_reset_flushes: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the barometric compensation block. A local
// fixed-point predictor tracks the calibration words and computes the
// expected reading for every accepted transaction; a monitor compares each
// strobed result in order. Directed tests cover reset calibration, field
// extremes, temperature bands, saturation and extreme calibrations, then
// random calibrations drive bulk traffic with random idle gaps.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic signed [btpc_pkg::TEMP_W-1:0] temperature;
        logic [btpc_pkg::PRESS_W-1:0]       pressure;
    } t_reading;

    typedef enum int {CAL_RANDOM, CAL_NEAR_TYPICAL, CAL_EXTREME} t_cal_mode;

    // indexes with no register behind them
    localparam logic [btpc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [btpc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam longint RAW_MAX     = (64'sd1 <<< btpc_pkg::RAW_W) - 1;
    localparam int     CYCLE_LIMIT = 800000;
    localparam int     PHASES      = 6;
    localparam int     PHASE_ITEMS = 300;

    localparam btpc_pkg::t_cal TYPICAL_CAL = {16'd40127, 16'd36924, 16'd23317,
                                              16'd23282, 16'd33464, 16'd28312};
    localparam btpc_pkg::t_cal ZERO_CAL    = '0;
    localparam btpc_pkg::t_cal FULL_CAL    = '1;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 start;
    logic                                 busy;
    logic [btpc_pkg::RAW_W-1:0]           i_raw_temperature;
    logic [btpc_pkg::RAW_W-1:0]           i_raw_pressure;
    logic                                 o_valid;
    logic signed [btpc_pkg::TEMP_W-1:0]   o_temperature_centi;
    logic [btpc_pkg::PRESS_W-1:0]         o_pressure_centi_mbar;
    logic                                 i_cfg_we;
    logic [btpc_pkg::CFG_IDX_W-1:0]       i_cfg_idx;
    logic [btpc_pkg::CFG_DATA_W-1:0]      i_cfg_data;

    btpc_pkg::t_cal cal_words;
    t_reading       pending_readings[$];
    int             errors;
    int             cycle_count;
    bit             back_to_back;

    baro_temp_pressure_compensation_top dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_raw_temperature     (i_raw_temperature),
        .i_raw_pressure        (i_raw_pressure),
        .o_valid               (o_valid),
        .o_temperature_centi   (o_temperature_centi),
        .o_pressure_centi_mbar (o_pressure_centi_mbar),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("baro_temp_pressure_compensation_top: mismatch");
            $finish;
        end
    end

    // second-order compensation, all shifts are floor shifts
    function automatic t_reading compensate(logic [btpc_pkg::RAW_W-1:0] d2,
                                            logic [btpc_pkg::RAW_W-1:0] d1);
        longint   dt, t1, off, sens, t2, off2, sens2, sq, sq2, temp_out, press;
        t_reading r;
        dt    = longint'(d2) - longint'(cal_words.ref_temperature) * 256;
        t1    = btpc_pkg::T_REF
              + ((dt * longint'(cal_words.temp_sensitivity)) >>> 23);
        off   = longint'(cal_words.offset_base) * 65536
              + ((longint'(cal_words.offset_tempco) * dt) >>> 7);
        sens  = longint'(cal_words.sens_base) * 32768
              + ((longint'(cal_words.sens_tempco) * dt) >>> 8);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (t1 < btpc_pkg::T_REF) begin
            sq    = (t1 - btpc_pkg::T_REF) * (t1 - btpc_pkg::T_REF);
            t2    = (dt * dt) >>> 31;
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (t1 < btpc_pkg::T_KNEE) begin
                sq2   = (t1 - btpc_pkg::T_KNEE) * (t1 - btpc_pkg::T_KNEE);
                off2  = off2 + 7 * sq2;
                sens2 = sens2 + ((11 * sq2) >>> 1);
            end
        end
        temp_out = t1 - t2;
        if (temp_out < btpc_pkg::TEMP_LOW)
            temp_out = btpc_pkg::TEMP_LOW;
        else if (temp_out > btpc_pkg::TEMP_HIGH)
            temp_out = btpc_pkg::TEMP_HIGH;
        press = (((longint'(d1) * (sens - sens2)) >>> 21) - (off - off2)) >>> 15;
        if (press < 0)
            press = 0;
        else if (press > btpc_pkg::PRESS_HIGH)
            press = btpc_pkg::PRESS_HIGH;
        r.temperature = temp_out[btpc_pkg::TEMP_W-1:0];
        r.pressure    = press[btpc_pkg::PRESS_W-1:0];
        return r;
    endfunction

    function automatic logic [15:0] draw_word(t_cal_mode mode, logic [15:0] typical);
        case (mode)
            CAL_NEAR_TYPICAL: return typical + 16'($urandom_range(0, 8191)) - 16'd4096;
            CAL_EXTREME:      return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:          return 16'($urandom);
        endcase
    endfunction

    function automatic logic [btpc_pkg::RAW_W-1:0] clamp_raw(longint v);
        if (v < 0)
            return '0;
        if (v > RAW_MAX)
            return '1;
        return v[btpc_pkg::RAW_W-1:0];
    endfunction

    // port write plus the predictor's copy; spare indexes leave the copy alone
    task automatic write_cal(input logic [btpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        case (idx)
            btpc_pkg::REG_SENS_BASE:        cal_words.sens_base        = value;
            btpc_pkg::REG_OFFSET_BASE:      cal_words.offset_base      = value;
            btpc_pkg::REG_SENS_TEMPCO:      cal_words.sens_tempco      = value;
            btpc_pkg::REG_OFFSET_TEMPCO:    cal_words.offset_tempco    = value;
            btpc_pkg::REG_REF_TEMPERATURE:  cal_words.ref_temperature  = value;
            btpc_pkg::REG_TEMP_SENSITIVITY: cal_words.temp_sensitivity = value;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // only called with nothing in flight
    task automatic load_cal(input btpc_pkg::t_cal c);
        write_cal(btpc_pkg::REG_SENS_BASE,        c.sens_base);
        write_cal(REG_SPARE_LO,                   16'($urandom));
        write_cal(btpc_pkg::REG_OFFSET_BASE,      c.offset_base);
        write_cal(btpc_pkg::REG_SENS_TEMPCO,      c.sens_tempco);
        write_cal(btpc_pkg::REG_OFFSET_TEMPCO,    c.offset_tempco);
        write_cal(btpc_pkg::REG_REF_TEMPERATURE,  c.ref_temperature);
        write_cal(REG_SPARE_HI,                   16'($urandom));
        write_cal(btpc_pkg::REG_TEMP_SENSITIVITY, c.temp_sensitivity);
        i_cfg_we = 1'b0;
    endtask

    // enters and leaves at a falling edge; start stays high for a back-to-back follower
    task automatic send_conversion(input logic [btpc_pkg::RAW_W-1:0] d2,
                                   input logic [btpc_pkg::RAW_W-1:0] d1);
        int unsigned gap;
        gap = back_to_back ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 23) == 0)
            back_to_back = !back_to_back;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start             = 1'b1;
        i_raw_temperature = d2;
        i_raw_pressure    = d1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_readings.push_back(compensate(d2, d1));
        @(negedge i_clk);
    endtask

    // hold off the sender until every reading is back
    task automatic drain;
        start = 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (btpc_pkg::LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic test_reset_calibration;
        // all words still zero after reset
        send_conversion('0, '0);
        send_conversion('1, '1);
        send_conversion(24'h800000, 24'h7FFFFF);
        drain();
    endtask

    task automatic test_field_extremes;
        load_cal(TYPICAL_CAL);
        send_conversion('0, '0);
        send_conversion('1, '0);
        send_conversion('0, '1);
        send_conversion('1, '1);
        send_conversion(24'd8569150, 24'd9085466);
        drain();
    endtask

    task automatic test_temperature_bands;
        int     targets[10] = '{9000, 5000, 2000, 1999, 0, -1500, -1501, -3000,
                                -4000, -20000};
        longint d2_wide;
        foreach (targets[k]) begin
            d2_wide = longint'(cal_words.ref_temperature) * 256
                    + ((longint'(targets[k]) - btpc_pkg::T_REF) * (64'sd1 <<< 23))
                      / longint'(cal_words.temp_sensitivity);
            send_conversion(clamp_raw(d2_wide), 24'd9085466);
        end
        drain();
    endtask

    task automatic test_calibration_extremes;
        load_cal(FULL_CAL);
        send_conversion('1, '1);
        send_conversion('0, '1);
        send_conversion(24'hFFFF00, 24'h400000);
        drain();
        load_cal(ZERO_CAL);
        send_conversion('1, '1);
        send_conversion('0, 24'h123456);
        drain();
    endtask

    task automatic test_random_traffic;
        btpc_pkg::t_cal             c;
        t_cal_mode                  mode;
        longint                     span, d2_wide;
        logic [btpc_pkg::RAW_W-1:0] d1;
        for (int phase = 0; phase < PHASES; phase++) begin
            mode = t_cal_mode'($urandom_range(0, 2));
            if (phase < 2)
                mode = CAL_NEAR_TYPICAL;
            c.sens_base        = draw_word(mode, TYPICAL_CAL.sens_base);
            c.offset_base      = draw_word(mode, TYPICAL_CAL.offset_base);
            c.sens_tempco      = draw_word(mode, TYPICAL_CAL.sens_tempco);
            c.offset_tempco    = draw_word(mode, TYPICAL_CAL.offset_tempco);
            c.ref_temperature  = draw_word(mode, TYPICAL_CAL.ref_temperature);
            c.temp_sensitivity = draw_word(mode, TYPICAL_CAL.temp_sensitivity);
            load_cal(c);
            back_to_back = $urandom_range(0, 1);
            repeat (PHASE_ITEMS) begin
                // mostly near the reference point so every temperature band is hit
                case ($urandom_range(0, 3))
                    0:       span = 64'sd1 <<< 10;
                    1:       span = 64'sd1 <<< 16;
                    2:       span = 64'sd1 <<< 20;
                    default: span = 0;
                endcase
                if (span == 0)
                    d2_wide = longint'($urandom_range(0, RAW_MAX));
                else
                    d2_wide = longint'(cal_words.ref_temperature) * 256
                            + longint'($urandom_range(0, 2 * span)) - span;
                case ($urandom_range(0, 15))
                    0:       d1 = '0;
                    1:       d1 = '1;
                    default: d1 = btpc_pkg::RAW_W'($urandom);
                endcase
                send_conversion(clamp_raw(d2_wide), d1);
            end
            drain();
        end
    endtask

    // monitor: each strobe is one transaction, checked against the oldest prediction
    always @(posedge i_clk) begin : check_reading
        t_reading want;
        if (i_rst_n && o_valid) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected result temperature %0d pressure %0d",
                         $time, o_temperature_centi, o_pressure_centi_mbar);
                errors++;
            end else begin
                want = pending_readings.pop_front();
                if (o_temperature_centi !== want.temperature) begin
                    $display("%0t: temperature expected %0d actual %0d",
                             $time, want.temperature, o_temperature_centi);
                    errors++;
                end
                if (o_pressure_centi_mbar !== want.pressure) begin
                    $display("%0t: pressure expected %0d actual %0d",
                             $time, want.pressure, o_pressure_centi_mbar);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors            = 0;
        cycle_count       = 0;
        back_to_back      = 1'b0;
        cal_words         = ZERO_CAL;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure    = '0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = btpc_pkg::REG_SENS_BASE;
        i_cfg_data        = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_calibration();
        test_field_extremes();
        test_temperature_bands();
        test_calibration_extremes();
        test_random_traffic();

        drain();
        repeat (btpc_pkg::LATENCY + 4) @(posedge i_clk);
        if (errors == 0)
            $display("baro_temp_pressure_compensation_top: match");
        else
            $display("baro_temp_pressure_compensation_top: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
hdl/btpc_pkg.sv
hdl/btpc_calc.sv
hdl/baro_temp_pressure_compensation_top.sv
sim/tb_top.sv
